// ===== src/mcbf_pkg.sv =====
package mcbf_pkg;

	localparam int MAX_DIM    = 4096;
	localparam int MAX_LEVELS = 12;

	localparam int DIM_W   = 13;
	localparam int POS_W   = 12;
	localparam int LVL_W   = 4;
	localparam int SLOT_W  = 14;
	localparam int ADDR_W  = 12;
	localparam int CH_W    = 8;
	localparam int PAIR_W  = 9;
	localparam int TOT_W   = 10;
	localparam int MEM_W   = 4 * PAIR_W;
	localparam int CIDX_W  = 8;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_WIDTH  = 8'd0;
	localparam logic [CIDX_W-1:0] REG_HEIGHT = 8'd1;

	typedef logic [3:0][CH_W-1:0]  pix_t;
	typedef logic [3:0][PAIR_W-1:0] pair_t;
	typedef logic [3:0][TOT_W-1:0]  tot_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EVAL = 5'b00010,
		ST_RD   = 5'b00100,
		ST_RES  = 5'b01000,
		ST_END  = 5'b10000
	} state_t;

	// floor(log2(max(w, h))) capped at the level limit
	function automatic logic [LVL_W-1:0] lower_levels(logic [DIM_W-1:0] w,
			logic [DIM_W-1:0] h);
		logic [DIM_W-1:0] m;
		logic [LVL_W-1:0] n;
		m = (w > h) ? w : h;
		n = '0;
		for (int i = 1; i < DIM_W; i++) begin
			if (m[i]) n = LVL_W'(i);
		end
		if (n > LVL_W'(MAX_LEVELS)) n = LVL_W'(MAX_LEVELS);
		return n;
	endfunction

endpackage

// ===== src/mcbf_ram.sv =====
module mcbf_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic             rd_en,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (wr_en) mem[addr] <= wdata;
		if (rd_en) rdata <= mem[addr];
	end

endmodule

// ===== src/mcbf_avg.sv =====
module mcbf_avg import mcbf_pkg::*; (
	input  tot_t tot,
	output pix_t px
);

	logic [TOT_W:0] rnd [4];

	// rounded quarter of each 2x2 channel sum
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			rnd[c] = {1'b0, tot[c]} + (TOT_W+1)'(2);
			px[c]  = rnd[c][CH_W+1:2];
		end
	end

endmodule

// ===== src/mipmap_chain_box_filter.sv =====
// mipmap chain generator, 2x2 box filter on RGBA8
// s_* channel: base image pixels in raster order, one beat per pixel.
// m_* channel: finished pixels of levels 1 and below, in completion order;
//   tlast marks the final result caused by one input pixel (a pixel that
//   finishes nothing gives no beat).
// cfg_* channel: index 0 writes image width, index 1 image height; a write to
//   either restarts the image at column 0, row 0. Write only while idle.
// One pixel at a time: a pixel is accepted only while idle; each level is
//   evaluated, a level that finishes nothing ends the pixel, a level that
//   finishes a pixel passes the result state (after a read state when the
//   line buffer is read), and a closing state ends the pixel. Three of four
//   base pixels stop at level 1; the registered read of the line buffer
//   adds the read state.
// The line buffer holds row pair sums, one slot per destination column,
//   levels packed back to back; it needs no clearing.
// Reset: width and height return to 1, position to 0,0, held pixels to 0.
// A stalled receiver holds one result in the output register and one in
//   a staging register; the cascade waits while both are full.
module mipmap_chain_box_filter import mcbf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [31:0]       s_tdata,   // red, green, blue, alpha
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [63:0]       m_tdata,   // level, col, row, out_red, out_green,
	                                     // out_blue, out_alpha, zero pad
	output logic              m_tlast,   // last
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]  cfg_data
);

	state_t state_q;
	logic [DIM_W-1:0] width_q, height_q, clamped;
	logic [POS_W-1:0] col_q, row_q;
	logic [LVL_W-1:0] levels;

	pix_t px_q;
	logic [POS_W-1:0] x_q, y_q, dx_q, dy_q;
	logic [DIM_W-1:0] sw_q, sh_q, off_q;
	logic [LVL_W-1:0] d_q;
	pair_t pair_q;
	tot_t tot_q;
	pix_t held_q [MAX_LEVELS];

	logic stg_v_q, out_v_q, out_last_q;
	logic [LVL_W-1:0] stg_lvl_q, out_lvl_q;
	logic [10:0] stg_col_q, stg_row_q, out_col_q, out_row_q;
	pix_t stg_px_q, out_px_q;

	logic [DIM_W-1:0] dw, dh;
	logic [POS_W-1:0] dx, dy;
	logic [SLOT_W-1:0] slot;
	logic [LVL_W-1:0] lidx;
	logic brk, hold_even, slot_oob, out_free, can_stage, accept;
	pair_t pair;
	tot_t tot_mem;
	pix_t avg;
	logic [MEM_W-1:0] mem_wdata, mem_rdata;
	logic mem_we, mem_re;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign levels    = lower_levels(width_q, height_q);

	// clamp configured dimension to 1..MAX_DIM
	always_comb begin
		if (cfg_data == '0) clamped = DIM_W'(1);
		else if (cfg_data > DIM_W'(MAX_DIM)) clamped = DIM_W'(MAX_DIM);
		else clamped = cfg_data;
	end

	// per level evaluation of the current source pixel
	always_comb begin
		lidx      = d_q - LVL_W'(1);
		dw        = (sw_q > DIM_W'(1)) ? (sw_q >> 1) : DIM_W'(1);
		dh        = (sh_q > DIM_W'(1)) ? (sh_q >> 1) : DIM_W'(1);
		brk       = ((sw_q > DIM_W'(1)) && ({1'b0, x_q} >= (sw_q & ~DIM_W'(1)))) ||
		            ((sh_q > DIM_W'(1)) && ({1'b0, y_q} >= (sh_q & ~DIM_W'(1))));
		hold_even = (sw_q > DIM_W'(1)) && !x_q[0];
		dx        = (sw_q > DIM_W'(1)) ? (x_q >> 1) : '0;
		dy        = (sh_q > DIM_W'(1)) ? (y_q >> 1) : '0;
		slot      = SLOT_W'(off_q) + SLOT_W'(dx);
		slot_oob  = slot >= SLOT_W'(MAX_DIM);
		for (int c = 0; c < 4; c++) begin
			if (sw_q == DIM_W'(1)) pair[c] = {px_q[c], 1'b0};
			else pair[c] = PAIR_W'(held_q[lidx][c]) + PAIR_W'(px_q[c]);
			mem_wdata[c*PAIR_W +: PAIR_W] = pair[c];
			tot_mem[c] = TOT_W'(mem_rdata[c*PAIR_W +: PAIR_W]) + TOT_W'(pair_q[c]);
		end
	end

	// line buffer access: write on even rows, read on odd rows
	assign mem_we = (state_q == ST_EVAL) && !brk && !hold_even && (sh_q != DIM_W'(1)) &&
	                !slot_oob && !y_q[0];
	assign mem_re = (state_q == ST_EVAL) && !brk && !hold_even && (sh_q != DIM_W'(1)) &&
	                !slot_oob && y_q[0];

	mcbf_ram #(.WIDTH(MEM_W), .DEPTH(MAX_DIM)) u_line (
		.clk   (clk),
		.wr_en (mem_we),
		.rd_en (mem_re),
		.addr  (slot[ADDR_W-1:0]),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	mcbf_avg u_avg (
		.tot (tot_q),
		.px  (avg)
	);

	assign out_free  = !out_v_q || m_tready;
	assign can_stage = !stg_v_q || out_free;

	// sequencer over levels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
			col_q    <= '0;
			row_q    <= '0;
			stg_v_q  <= 1'b0;
			out_v_q  <= 1'b0;
			for (int i = 0; i < MAX_LEVELS; i++) held_q[i] <= '0;
		end else begin
			if (out_v_q && m_tready) out_v_q <= 1'b0;

			// base position advance
			if (accept) begin
				if ({1'b0, col_q} + DIM_W'(1) >= width_q) begin
					col_q <= '0;
					if ({1'b0, row_q} + DIM_W'(1) >= height_q) row_q <= '0;
					else row_q <= row_q + POS_W'(1);
				end else begin
					col_q <= col_q + POS_W'(1);
				end
			end

			// register writes restart the image
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_WIDTH: begin
						width_q <= clamped;
						col_q   <= '0;
						row_q   <= '0;
					end
					REG_HEIGHT: begin
						height_q <= clamped;
						col_q    <= '0;
						row_q    <= '0;
					end
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						px_q    <= s_tdata;
						x_q     <= col_q;
						y_q     <= row_q;
						sw_q    <= width_q;
						sh_q    <= height_q;
						off_q   <= '0;
						d_q     <= LVL_W'(1);
						state_q <= (levels == '0) ? ST_END : ST_EVAL;
					end
				end
				ST_EVAL: begin
					dx_q   <= dx;
					dy_q   <= dy;
					pair_q <= pair;
					if (brk) begin
						state_q <= ST_END;
					end else if (hold_even) begin
						held_q[lidx] <= px_q;
						state_q      <= ST_END;
					end else if (sh_q == DIM_W'(1)) begin
						for (int c = 0; c < 4; c++) tot_q[c] <= {pair[c], 1'b0};
						state_q <= ST_RES;
					end else if (slot_oob || !y_q[0]) begin
						state_q <= ST_END;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					tot_q   <= tot_mem;
					state_q <= ST_RES;
				end
				ST_RES: begin
					if (can_stage) begin
						if (stg_v_q) begin
							out_v_q    <= 1'b1;
							out_last_q <= 1'b0;
							out_lvl_q  <= stg_lvl_q;
							out_col_q  <= stg_col_q;
							out_row_q  <= stg_row_q;
							out_px_q   <= stg_px_q;
						end
						stg_v_q   <= 1'b1;
						stg_lvl_q <= d_q;
						stg_col_q <= dx_q[10:0];
						stg_row_q <= dy_q[10:0];
						stg_px_q  <= avg;
						px_q      <= avg;
						x_q       <= dx_q;
						y_q       <= dy_q;
						off_q     <= off_q + dw;
						sw_q      <= dw;
						sh_q      <= dh;
						d_q       <= d_q + LVL_W'(1);
						state_q   <= (d_q == levels) ? ST_END : ST_EVAL;
					end
				end
				ST_END: begin
					if (!stg_v_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_v_q    <= 1'b1;
						out_last_q <= 1'b1;
						out_lvl_q  <= stg_lvl_q;
						out_col_q  <= stg_col_q;
						out_row_q  <= stg_row_q;
						out_px_q   <= stg_px_q;
						stg_v_q    <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {6'd0, out_px_q[3], out_px_q[2], out_px_q[1], out_px_q[0],
	                   out_row_q, out_col_q, out_lvl_q};

`ifndef SYNTHESIS
	// nothing staged once the sequencer is idle
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !stg_v_q)
		else $error("staged result left behind at idle");

	// line buffer data is only consumed right after a read
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD |-> $past(mem_re))
		else $error("read state without a line buffer read");

	// level counter stays within the level count
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EVAL |-> (d_q != '0) && (d_q <= levels))
		else $error("level counter out of range");
`endif

endmodule
